@@ hw/rtl/ft_frame_decode_lowpass_assert.svh @@
// Assertion macros for the frame decode low-pass block.
// Used by the top level; expects signals clock and reset in scope.
`ifndef FT_FRAME_DECODE_LOWPASS_ASSERT_SVH
`define FT_FRAME_DECODE_LOWPASS_ASSERT_SVH

// same-cycle implication
`define FTFD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/ftfd_pkg.sv @@
// Shared types, constants and helpers for the frame decode low-pass block.
// No dependencies; imported by every module of the block.
package ftfd_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ALPHA_W   = 16;
   localparam int GAIN_W    = 16;
   localparam int WORD_W    = 16;
   localparam int VAL_W     = WORD_W + 1;
   localparam int OUT_W     = 25;
   localparam int STATE_W   = FRAC_BITS + VAL_W + 1;
   localparam int PROD_W    = STATE_W + ALPHA_W + 1;
   localparam int SM_SHIFT  = FRAC_BITS - 8;
   localparam int ANG_SHIFT = FRAC_BITS + 8;
   localparam int LANE_NUM  = 3;
   localparam int SLOT_NUM  = 3;
   localparam longint OUT_LIMIT = 64'sd8388608;

   // frame kinds
   localparam logic [1:0] KIND_MF   = 2'd0;
   localparam logic [1:0] KIND_FM   = 2'd1;
   localparam logic [1:0] KIND_TILT = 2'd2;

   // filter state slots inside a lane
   localparam logic [1:0] SLOT_MF   = 2'd0;
   localparam logic [1:0] SLOT_FM   = 2'd1;
   localparam logic [1:0] SLOT_TILT = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TILT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROLL  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH = 2'd3;

   localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd2471;
   localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd1671;

   typedef struct packed {
      logic       upd;
      logic       neg;
      logic [1:0] slot;
   } lane_ctrl_type;

   typedef struct packed {
      logic signed [STATE_W-1:0] y;
      logic signed [OUT_W-1:0]   smooth;
      logic signed [VAL_W-1:0]   value;
   } lane_res_type;

   // result word, value_a in the lowest bits
   typedef struct packed {
      logic signed [OUT_W-1:0] pitch_angle;
      logic signed [OUT_W-1:0] roll_angle;
      logic signed [OUT_W-1:0] smooth_c;
      logic signed [OUT_W-1:0] smooth_b;
      logic signed [OUT_W-1:0] smooth_a;
      logic signed [VAL_W-1:0] value_c;
      logic signed [VAL_W-1:0] value_b;
      logic signed [VAL_W-1:0] value_a;
   } rsp_data_type;

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
      logic signed [63:0] r;
      if (v > OUT_LIMIT) begin
         r = OUT_LIMIT;
      end else if (v < -OUT_LIMIT) begin
         r = -OUT_LIMIT;
      end else begin
         r = v;
      end
      return OUT_W'(r);
   endfunction

endpackage

@@ hw/rtl/ftfd_lane.sv @@
// One axis lane: word sign handling, filter state slots and the low-pass update.
// Depends on ftfd_pkg.
module ftfd_lane
   import ftfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [WORD_W-1:0]   word,
   input  lane_ctrl_type       ctrl,
   input  logic                upd_step,
   input  logic [ALPHA_W-1:0]  alpha,
   output lane_res_type        res
);

   logic signed [STATE_W-1:0] slot_ff [SLOT_NUM];
   logic signed [VAL_W-1:0]   x;
   logic signed [STATE_W-1:0] target;
   logic signed [STATE_W-1:0] y_cur;
   logic signed [STATE_W-1:0] diff;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic signed [STATE_W-1:0] y_in, y_ff;
   logic signed [STATE_W-1:0] sm_w;

   always_comb begin
      x = ctrl.neg ? -$signed({word[WORD_W-1], word}) : $signed({word[WORD_W-1], word});
      target = {{(STATE_W-VAL_W-FRAC_BITS){x[VAL_W-1]}}, x, {FRAC_BITS{1'b0}}};
      case (ctrl.slot)
         SLOT_MF: y_cur = slot_ff[0];
         SLOT_FM: y_cur = slot_ff[1];
         default: y_cur = slot_ff[2];
      endcase
      diff    = target - y_cur;
      prod_in = $signed({1'b0, alpha}) * diff;
      y_in    = y_cur + STATE_W'(prod_ff >>> ALPHA_W);
      sm_w    = y_ff >>> SM_SHIFT;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (upd_step) begin
         y_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_NUM; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (upd_step && ctrl.upd) begin
         case (ctrl.slot)
            SLOT_MF: slot_ff[0] <= y_in;
            SLOT_FM: slot_ff[1] <= y_in;
            default: slot_ff[2] <= y_in;
         endcase
      end
   end

   assign res.value  = x;
   assign res.smooth = sat_out(64'(sm_w));
   assign res.y      = y_ff;

endmodule

@@ hw/rtl/ftfd_merge.sv @@
// Merge stage: tilt gain products and selection of lane results into a result word.
// Depends on ftfd_pkg.
module ftfd_merge
   import ftfd_pkg::*;
(
   input  lane_res_type       lane_res [LANE_NUM],
   input  logic [1:0]         kind,
   input  logic               accepted,
   input  logic [GAIN_W-1:0]  roll_gain,
   input  logic [GAIN_W-1:0]  pitch_gain,
   output rsp_data_type       rsp_data
);

   logic signed [PROD_W-1:0] roll_prod, pitch_prod;
   logic signed [PROD_W-1:0] roll_sh, pitch_sh;

   always_comb begin
      roll_prod  = lane_res[0].y * $signed({1'b0, roll_gain});
      pitch_prod = lane_res[1].y * $signed({1'b0, pitch_gain});
      roll_sh    = roll_prod >>> ANG_SHIFT;
      pitch_sh   = pitch_prod >>> ANG_SHIFT;

      rsp_data = '0;
      if (accepted) begin
         rsp_data.value_a  = lane_res[0].value;
         rsp_data.value_b  = lane_res[1].value;
         rsp_data.smooth_a = lane_res[0].smooth;
         rsp_data.smooth_b = lane_res[1].smooth;
         if (kind == KIND_TILT) begin
            rsp_data.roll_angle  = sat_out(64'(roll_sh));
            rsp_data.pitch_angle = sat_out(64'(pitch_sh));
         end else begin
            rsp_data.value_c  = lane_res[2].value;
            rsp_data.smooth_c = lane_res[2].smooth;
         end
      end
   end

endmodule

@@ hw/rtl/ft_frame_decode_lowpass.sv @@
// Top level of the sensor frame decoder with per-axis low-pass smoothing.
// Depends on ftfd_pkg, ftfd_lane, ftfd_merge and ft_frame_decode_lowpass_assert.svh.
//
// Channel   Direction  Handshake              Payload
// req_*     in         req_tvalid/req_tready  tuser: mode; tdata: byte_1..byte_6
// rsp_*     out        rsp_tvalid/rsp_tready  tuser: frame_kind, accepted; tdata: values
// csr_*     in         csr_wr_en              csr_index, csr_wdata
//
// Each word steps through accept, lane multiply, state update and gain multiply into
// the output register, steps set by the lane alpha and the merge gain multipliers.
// Reset (synchronous) clears filter state and loads register defaults.
// A stalled result holds in the output register; the next word is taken only
// after it has moved there.
`include "ft_frame_decode_lowpass_assert.svh"

module ft_frame_decode_lowpass
   import ftfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,   // byte_1, byte_2, .. byte_6
   input  logic [1:0]           req_tuser,   // mode
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [175:0]         rsp_tdata,   // value_a/b/c, smooth_a/b/c, roll, pitch
   output logic [2:0]           rsp_tuser,   // frame_kind, accepted
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [47:0]        bytes_ff;
   logic [1:0]         kind_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic               tilt_ff;
   logic [GAIN_W-1:0]  roll_gain_ff, pitch_gain_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff;
   logic [2:0]         rsp_user_ff;

   logic               req_take, rsp_load, is_force, accepted;
   lane_ctrl_type      lane_ctrl [LANE_NUM];
   lane_res_type       lane_res  [LANE_NUM];
   rsp_data_type       merge_data;
   logic [1:0]         slot_sel;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      is_force = (kind_ff == KIND_MF) || (kind_ff == KIND_FM);
      accepted = is_force || ((kind_ff == KIND_TILT) && tilt_ff);
      case (kind_ff)
         KIND_MF: slot_sel = SLOT_MF;
         KIND_FM: slot_sel = SLOT_FM;
         default: slot_sel = SLOT_TILT;
      endcase
      for (int i = 0; i < LANE_NUM; i++) begin
         lane_ctrl[i].neg  = is_force;
         lane_ctrl[i].slot = slot_sel;
         lane_ctrl[i].upd  = is_force || ((kind_ff == KIND_TILT) && tilt_ff && (i < 2));
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_MUL;
         ST_MUL:  state_in = ST_UPD;
         ST_UPD:  state_in = ST_FIN;
         ST_FIN:  if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         alpha_ff      <= ALPHA_RST;
         tilt_ff       <= 1'b1;
         roll_gain_ff  <= GAIN_RST;
         pitch_gain_ff <= GAIN_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_ALPHA: alpha_ff      <= csr_wdata[ALPHA_W-1:0];
               REG_TILT:  tilt_ff       <= csr_wdata[0];
               REG_ROLL:  roll_gain_ff  <= csr_wdata[GAIN_W-1:0];
               REG_PITCH: pitch_gain_ff <= csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         bytes_ff <= req_tdata;
         kind_ff  <= req_tuser;
      end
      if (rsp_load) begin
         rsp_data_ff <= merge_data;
         rsp_user_ff <= {accepted, kind_ff};
      end
   end

   for (genvar g = 0; g < LANE_NUM; g++) begin : g_lane
      ftfd_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .word     (bytes_ff[g*2*8 +: WORD_W]),
         .ctrl     (lane_ctrl[g]),
         .upd_step (state_ff == ST_UPD),
         .alpha    (alpha_ff),
         .res      (lane_res[g])
      );
   end

   ftfd_merge u_merge (
      .lane_res   (lane_res),
      .kind       (kind_ff),
      .accepted   (accepted),
      .roll_gain  (roll_gain_ff),
      .pitch_gain (pitch_gain_ff),
      .rsp_data   (merge_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `FTFD_ASSERT_NEXT(a_accept_seq, req_tvalid && req_tready, (state_ff == ST_MUL) ##1 (state_ff == ST_UPD), "word accepted but lane sequence did not follow")
   `FTFD_ASSERT_NOW(a_reject_zero, rsp_tvalid && !rsp_tuser[2], rsp_tdata == '0, "rejected frame carries nonzero values")
   `FTFD_ASSERT_NOW(a_angle_tilt, rsp_tvalid && (rsp_tuser[1:0] != KIND_TILT), rsp_tdata[175:126] == '0, "angles set on a non-tilt frame")
   `FTFD_ASSERT_NOW(a_tilt_c_zero, rsp_tvalid && (rsp_tuser[1:0] == KIND_TILT), (rsp_tdata[50:34] == '0) && (rsp_tdata[125:101] == '0), "third axis set on a tilt frame")

endmodule
